/* rtl/btsl_pkg.sv */
// Package for the boot table section loader: core count, field widths,
// result kind codes, register indexes and register reset values.
// No dependencies.
package btsl_pkg;

	localparam int NUM_CORES = 8;
	localparam int CORE_W = $clog2(NUM_CORES);
	localparam int WORD_W = 32;
	localparam int WLEFT_W = 31;

	localparam logic [3:0] CORES_ALL = (NUM_CORES > 15) ? 4'd15 : 4'(NUM_CORES);

	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_ENTRY = 2'd1;
	localparam logic [1:0] KIND_FINISH = 2'd2;

	localparam logic [1:0] REG_LOCAL_LIMIT = 2'd0;
	localparam logic [1:0] REG_GLOBAL_BASE = 2'd1;
	localparam logic [1:0] REG_CORE_STRIDE = 2'd2;

	localparam logic [WORD_W-1:0] LOCAL_LIMIT_RST = 32'h0088_0000;
	localparam logic [WORD_W-1:0] GLOBAL_BASE_RST = 32'h1000_0000;
	localparam logic [WORD_W-1:0] CORE_STRIDE_RST = 32'h0100_0000;

endpackage

/* rtl/boot_table_section_loader_unit.sv */
// Top level of the boot table section loader: parses a multicore boot image
// into memory writes, core entry points and a finish marker.
// Depends on btsl_pkg.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+------------------------------------
//  input    | in        | in_valid / in_stall  | image_word, restart
//  result   | out       | out_valid / out_stall| kind, address, data, core, cores_loaded
//  config   | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// An item's result is registered: the input register feeds the parse step, which loads
// the result register once the result side advances.
// One item is accepted per cycle while the result side is not stalled.
// Reset returns the parser to expecting core zero's header word and loads
// the register defaults. A stalled result holds both stages in place.
module boot_table_section_loader_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [btsl_pkg::WORD_W-1:0]    image_word,
	input  logic                           restart,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [1:0]                     kind,
	output logic [btsl_pkg::WORD_W-1:0]    address,
	output logic [btsl_pkg::WORD_W-1:0]    data,
	output logic [2:0]                     core,
	output logic [3:0]                     cores_loaded,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [1:0]                     cfg_index,
	input  logic [btsl_pkg::WORD_W-1:0]    cfg_data
);
	import btsl_pkg::*;

	localparam logic [2:0] PH_HEADER = 3'd0;
	localparam logic [2:0] PH_ENTRY = 3'd1;
	localparam logic [2:0] PH_SIZE = 3'd2;
	localparam logic [2:0] PH_ADDR = 3'd3;
	localparam logic [2:0] PH_DATA = 3'd4;
	localparam logic [2:0] PH_DONE = 3'd5;

	logic [WORD_W-1:0]  local_limit_q;
	logic [WORD_W-1:0]  global_base_q;
	logic [WORD_W-1:0]  core_stride_q;

	logic               valid_s1;
	logic [WORD_W-1:0]  word_s1;
	logic               restart_s1;

	logic [2:0]         phase_q;
	logic [CORE_W-1:0]  core_idx_q;
	logic [WLEFT_W-1:0] words_left_q;
	logic [WORD_W-1:0]  wptr_q;

	logic               out_valid_q;
	logic [1:0]         kind_q;
	logic [WORD_W-1:0]  address_q;
	logic [WORD_W-1:0]  data_q;
	logic [2:0]         core_q;
	logic [3:0]         loaded_q;

	logic               advance;
	logic               fire;

	logic [2:0]         ph_cur;
	logic [CORE_W-1:0]  core_cur;
	logic [WLEFT_W-1:0] words_cur;
	logic [CORE_W:0]    core_inc;
	logic [WORD_W-1:0]  xlat_addr;
	logic [WLEFT_W-1:0] words_dec;

	logic [2:0]         phase_d;
	logic [CORE_W-1:0]  core_idx_d;
	logic [WLEFT_W-1:0] words_left_d;
	logic [WORD_W-1:0]  wptr_d;
	logic               res_d;
	logic [1:0]         kind_d;
	logic [WORD_W-1:0]  address_d;
	logic [WORD_W-1:0]  data_d;
	logic [3:0]         loaded_d;

	assign advance = !out_valid_q || !out_stall;
	assign fire = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;
	assign cfg_ready = 1'b1;

	assign ph_cur = restart_s1 ? PH_HEADER : phase_q;
	assign core_cur = restart_s1 ? '0 : core_idx_q;
	assign words_cur = restart_s1 ? '0 : words_left_q;
	assign core_inc = {1'b0, core_cur} + {{CORE_W{1'b0}}, 1'b1};
	assign words_dec = words_cur - {{(WLEFT_W-1){1'b0}}, 1'b1};
	assign xlat_addr = (word_s1 < local_limit_q) ?
		global_base_q + WORD_W'(core_stride_q * WORD_W'(core_cur)) + word_s1 : word_s1;

	always_comb begin
		phase_d = ph_cur;
		core_idx_d = core_cur;
		words_left_d = words_cur;
		wptr_d = wptr_q;
		res_d = 1'b0;
		kind_d = KIND_WRITE;
		address_d = '0;
		data_d = '0;
		loaded_d = '0;
		unique case (ph_cur)
			PH_HEADER: begin
				if (core_cur == CORE_W'(1) && word_s1 == '0) begin
					phase_d = PH_DONE;
					res_d = 1'b1;
					kind_d = KIND_FINISH;
					loaded_d = 4'd1;
				end else begin
					phase_d = PH_ENTRY;
				end
			end
			PH_ENTRY: begin
				phase_d = PH_SIZE;
				res_d = 1'b1;
				kind_d = KIND_ENTRY;
				address_d = word_s1;
			end
			PH_SIZE: begin
				if (word_s1 == '0) begin
					if (core_inc >= (CORE_W+1)'(NUM_CORES)) begin
						phase_d = PH_DONE;
						res_d = 1'b1;
						kind_d = KIND_FINISH;
						loaded_d = CORES_ALL;
					end else begin
						core_idx_d = core_inc[CORE_W-1:0];
						phase_d = PH_HEADER;
					end
				end else begin
					words_left_d = {1'b0, word_s1[WORD_W-1:2]} +
						{{(WLEFT_W-1){1'b0}}, |word_s1[1:0]};
					phase_d = PH_ADDR;
				end
			end
			PH_ADDR: begin
				wptr_d = xlat_addr;
				phase_d = (words_cur != '0) ? PH_DATA : PH_SIZE;
			end
			PH_DATA: begin
				res_d = 1'b1;
				kind_d = KIND_WRITE;
				address_d = wptr_q;
				data_d = word_s1;
				wptr_d = wptr_q + WORD_W'(4);
				words_left_d = words_dec;
				if (words_dec == '0) begin
					phase_d = PH_SIZE;
				end
			end
			default: begin
				phase_d = ph_cur;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_limit_q <= LOCAL_LIMIT_RST;
			global_base_q <= GLOBAL_BASE_RST;
			core_stride_q <= CORE_STRIDE_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_LOCAL_LIMIT: local_limit_q <= cfg_data;
				REG_GLOBAL_BASE: global_base_q <= cfg_data;
				REG_CORE_STRIDE: core_stride_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			word_s1 <= image_word;
			restart_s1 <= restart;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			core_idx_q <= '0;
			words_left_q <= '0;
			wptr_q <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			core_idx_q <= core_idx_d;
			words_left_q <= words_left_d;
			wptr_q <= wptr_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= fire && res_d;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res_d) begin
			kind_q <= kind_d;
			address_q <= address_d;
			data_q <= data_d;
			core_q <= (kind_d == KIND_FINISH) ? 3'd0 : 3'(core_cur);
			loaded_q <= loaded_d;
		end
	end

	assign out_valid = out_valid_q;
	assign kind = kind_q;
	assign address = address_q;
	assign data = data_q;
	assign core = core_q;
	assign cores_loaded = loaded_q;

endmodule

/* bench/boot_table_section_loader_unit_tb.sv */
// Testbench for boot_table_section_loader_unit: streams directed and random boot images,
// predicts every write, entry point and finish item, and checks each result in order.
// Depends on btsl_pkg and the RTL of the loader.
module boot_table_section_loader_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import btsl_pkg::*;

	typedef enum logic [2:0] {
		PARSE_HEADER,
		PARSE_ENTRY,
		PARSE_SIZE,
		PARSE_ADDR,
		PARSE_DATA,
		PARSE_DONE
	} parse_state_t;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic              rst;
	} image_item_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [WORD_W-1:0] addr;
		logic [WORD_W-1:0] data;
		logic [2:0]        core;
		logic [3:0]        loaded;
	} load_result_t;

	localparam logic [3:0] ALL_CORES_LOADED = (NUM_CORES > 15) ? 4'd15 : 4'(NUM_CORES);
	localparam int HOLD_CYCLES = 300;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [WORD_W-1:0] image_word = '0;
	logic              restart = 1'b0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [1:0]        kind;
	logic [WORD_W-1:0] address;
	logic [WORD_W-1:0] data;
	logic [2:0]        core;
	logic [3:0]        cores_loaded;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [1:0]        cfg_index = '0;
	logic [WORD_W-1:0] cfg_data = '0;

	boot_table_section_loader_unit u_top (.*);

	// Register copies and parser state of the prediction.
	logic [WORD_W-1:0] local_limit = LOCAL_LIMIT_RST;
	logic [WORD_W-1:0] global_base = GLOBAL_BASE_RST;
	logic [WORD_W-1:0] core_stride = CORE_STRIDE_RST;
	parse_state_t      parse_st = PARSE_HEADER;
	int unsigned       cur_core = 0;
	int unsigned       words_left = 0;
	logic [WORD_W-1:0] write_ptr = '0;

	image_item_t  pending_words[$];
	load_result_t expected_results[$];

	bit          idle_on = 1'b1;
	int unsigned send_gap = 0;
	int unsigned recv_wait = 0;
	int unsigned hold_left = 0;
	int unsigned burst_req = 0;
	int unsigned burst_ack = 0;
	int unsigned words_planned = 0;
	int unsigned words_taken = 0;
	int unsigned n_writes = 0;
	int unsigned n_entries = 0;
	int unsigned n_finishes = 0;
	int unsigned n_settings = 1;
	int unsigned mismatches = 0;

	image_item_t  next_item;
	load_result_t predicted;
	load_result_t want;
	logic         offer;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic bit parse_word(input logic [WORD_W-1:0] w, input logic rst,
			output load_result_t r);
		logic [WORD_W-1:0] dest;
		r = '0;
		if (rst) begin
			parse_st = PARSE_HEADER;
			cur_core = 0;
			words_left = 0;
		end
		case (parse_st)
			PARSE_HEADER: begin
				if (cur_core == 1 && w == '0) begin
					parse_st = PARSE_DONE;
					r.kind = KIND_FINISH;
					r.loaded = 4'd1;
					return 1'b1;
				end
				parse_st = PARSE_ENTRY;
				return 1'b0;
			end
			PARSE_ENTRY: begin
				parse_st = PARSE_SIZE;
				r.kind = KIND_ENTRY;
				r.addr = w;
				r.core = cur_core[2:0];
				return 1'b1;
			end
			PARSE_SIZE: begin
				if (w == '0) begin
					cur_core++;
					if (cur_core >= NUM_CORES) begin
						parse_st = PARSE_DONE;
						r.kind = KIND_FINISH;
						r.loaded = ALL_CORES_LOADED;
						return 1'b1;
					end
					parse_st = PARSE_HEADER;
					return 1'b0;
				end
				words_left = (w >> 2) + ((w[1:0] != 2'd0) ? 1 : 0);
				parse_st = PARSE_ADDR;
				return 1'b0;
			end
			PARSE_ADDR: begin
				dest = w;
				if (w < local_limit)
					dest = global_base + core_stride * cur_core + w;
				write_ptr = dest;
				parse_st = (words_left != 0) ? PARSE_DATA : PARSE_SIZE;
				return 1'b0;
			end
			PARSE_DATA: begin
				r.kind = KIND_WRITE;
				r.addr = write_ptr;
				r.data = w;
				r.core = cur_core[2:0];
				write_ptr = write_ptr + 32'd4;
				words_left--;
				if (words_left == 0)
					parse_st = PARSE_SIZE;
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			offer = in_valid;
			if (in_valid && !in_stall) begin
				if (parse_word(image_word, restart, predicted))
					expected_results.push_back(predicted);
				words_taken++;
				offer = 1'b0;
			end
			if (!offer) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending_words.size() != 0) begin
					next_item = pending_words.pop_front();
					image_word <= next_item.word;
					restart <= next_item.rst;
					offer = 1'b1;
					send_gap = idle_on ? $urandom_range(0, 7) : 0;
				end
			end
			in_valid <= offer;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result: kind %0d address %h data %h",
						kind, address, data);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					case (want.kind)
						KIND_WRITE: n_writes++;
						KIND_ENTRY: n_entries++;
						default: n_finishes++;
					endcase
					if (kind !== want.kind) begin
						$error("kind: expected %0d, got %0d", want.kind, kind);
						mismatches++;
					end
					if (address !== want.addr) begin
						$error("address: expected %h, got %h", want.addr, address);
						mismatches++;
					end
					if (data !== want.data) begin
						$error("data: expected %h, got %h", want.data, data);
						mismatches++;
					end
					if (core !== want.core) begin
						$error("core: expected %0d, got %0d", want.core, core);
						mismatches++;
					end
					if (cores_loaded !== want.loaded) begin
						$error("cores_loaded: expected %0d, got %0d",
							want.loaded, cores_loaded);
						mismatches++;
					end
				end
				recv_wait = idle_on ? $urandom_range(0, 7) : 0;
			end else if (recv_wait > 0) begin
				recv_wait--;
			end
			if (burst_ack != burst_req) begin
				burst_ack = burst_req;
				hold_left = HOLD_CYCLES;
			end else if (hold_left > 0) begin
				hold_left--;
			end
			out_stall <= (recv_wait > 0) || (hold_left > 0);
		end
	end

	task automatic put_word(input logic [WORD_W-1:0] w, input logic rst);
		pending_words.push_back('{word: w, rst: rst});
		words_planned++;
	endtask

	function automatic logic [WORD_W-1:0] pick_dest();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return (local_limit == '0) ? $urandom : $urandom % local_limit;
			2: return local_limit - 32'd1;
			3: return local_limit;
			4: return 32'hFFFF_FFF0 + $urandom_range(0, 15);
			default: return $urandom_range(0, 63) * 4;
		endcase
	endfunction

	task automatic gen_image();
		image_item_t       img[$];
		logic [WORD_W-1:0] hdr;
		logic [WORD_W-1:0] sz;
		int unsigned       n_data;
		bit                single;
		int                cut;
		single = ($urandom_range(0, 3) == 0);
		img.push_back('{word: $urandom, rst: 1'b1});
		for (int c = 0; c < NUM_CORES; c++) begin
			if (c > 0) begin
				if (c == 1 && single) begin
					img.push_back('{word: '0, rst: 1'b0});
					break;
				end
				hdr = ($urandom_range(0, 3) == 0) ? '0 : $urandom;
				if (c == 1 && hdr == '0)
					hdr = 32'd1;
				img.push_back('{word: hdr, rst: 1'b0});
			end
			img.push_back('{word: $urandom, rst: 1'b0});
			repeat ($urandom_range(0, 2)) begin
				sz = ($urandom_range(0, 9) == 0) ?
					$urandom_range(33, 200) : $urandom_range(1, 24);
				n_data = (sz >> 2) + ((sz[1:0] != 2'd0) ? 1 : 0);
				img.push_back('{word: sz, rst: 1'b0});
				img.push_back('{word: pick_dest(), rst: 1'b0});
				repeat (n_data)
					img.push_back('{word: $urandom, rst: 1'b0});
			end
			img.push_back('{word: '0, rst: 1'b0});
		end
		cut = ($urandom_range(0, 4) == 0) ? $urandom_range(1, img.size() - 1) : img.size();
		while (img.size() > cut)
			void'(img.pop_back());
		foreach (img[i])
			put_word(img[i].word, img[i].rst);
		if (cut == img.size() && $urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 3))
				pending_words.push_back('{word: $urandom, rst: 1'b0});
		end
	endtask

	task automatic gen_traffic(input int unsigned target);
		while (words_planned < target) begin
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 8))
					put_word($urandom, $urandom_range(0, 7) == 0);
			end else begin
				gen_image();
			end
		end
	endtask

	task automatic drain();
		int unsigned k;
		k = 0;
		while ((pending_words.size() != 0 || in_valid || expected_results.size() != 0)
				&& k < 100000) begin
			@(negedge clk);
			k++;
		end
		repeat (6) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [WORD_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_LOCAL_LIMIT: local_limit = val;
			REG_GLOBAL_BASE: global_base = val;
			default: core_stride = val;
		endcase
	endtask

	task automatic set_regs(input logic [WORD_W-1:0] limit, input logic [WORD_W-1:0] base,
			input logic [WORD_W-1:0] stride);
		write_reg(REG_LOCAL_LIMIT, limit);
		write_reg(REG_GLOBAL_BASE, base);
		write_reg(REG_CORE_STRIDE, stride);
		n_settings++;
	endtask

	task automatic hold_results_after(input int unsigned n);
		int unsigned start;
		start = words_taken;
		while (words_taken < start + n && (pending_words.size() != 0 || in_valid))
			@(negedge clk);
		burst_req++;
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Huge size that rounds up without wrap, cut short by a restart.
		put_word(32'h0000_0000, 1'b1);
		put_word(32'hFFFF_FFFF, 1'b0);
		put_word(32'hFFFF_FFFF, 1'b0);
		put_word(32'h0000_0000, 1'b0);
		put_word(32'hFFFF_FFFF, 1'b0);
		put_word(32'h0000_0000, 1'b0);
		// Zero first size, then a zero core 1 header ends a single-core image.
		put_word(32'hFFFF_FFFF, 1'b1);
		put_word(32'h0000_0000, 1'b0);
		put_word(32'h0000_0000, 1'b0);
		put_word(32'h0000_0000, 1'b0);
		put_word(32'h1234_5678, 1'b0);
		// Untranslated address that wraps, rounding, and both sides of the limit.
		put_word(32'h0000_0001, 1'b1);
		put_word(32'h8000_0000, 1'b0);
		put_word(32'h0000_0005, 1'b0);
		put_word(32'hFFFF_FFFC, 1'b0);
		put_word(32'hA5A5_5A5A, 1'b0);
		put_word(32'h5A5A_A5A5, 1'b0);
		put_word(32'h0000_0003, 1'b0);
		put_word(local_limit - 32'd1, 1'b0);
		put_word(32'h0F0F_F0F0, 1'b0);
		put_word(32'h0000_0004, 1'b0);
		put_word(local_limit, 1'b0);
		put_word(32'hF0F0_0F0F, 1'b0);
		put_word(32'h0000_0000, 1'b0);

		idle_on = 1'b1;
		gen_traffic(420);
		hold_results_after(100);
		drain();

		set_regs('0, '0, '0);
		idle_on = 1'b0;
		gen_traffic(760);
		drain();

		set_regs('1, '1, '1);
		idle_on = 1'b1;
		gen_traffic(1100);
		drain();

		set_regs($urandom, $urandom, $urandom);
		gen_traffic(1420);
		hold_results_after(150);
		drain();

		set_regs($urandom_range(0, 32'h0100_0000), $urandom, $urandom);
		gen_traffic(1720);
		drain();

		if (expected_results.size() != 0) begin
			$error("%0d expected results never arrived", expected_results.size());
			mismatches++;
		end
		$display("Checked %0d results (%0d writes, %0d entry points, %0d finishes)",
			n_writes + n_entries + n_finishes, n_writes, n_entries, n_finishes);
		$display("from %0d image words across %0d register settings, %s",
			words_taken, n_settings, "with random idling, long result stalls and pauses.");
		if (mismatches == 0) begin
			$display("[boot_table_section_loader_unit] OK");
		end else begin
			$display("[boot_table_section_loader_unit] ERROR");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("[boot_table_section_loader_unit] ERROR");
		$finish;
	end

endmodule
